>>> rtl/core/seam_feather_weight_defines.svh
// Assertion macros for the seam feather weight block
`ifndef SEAM_FEATHER_WEIGHT_DEFINES_SVH
`define SEAM_FEATHER_WEIGHT_DEFINES_SVH

// prop must hold at every clock edge out of reset
`define SFW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expr must never be true out of reset
`define SFW_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

>>> rtl/core/sfw_pkg.sv
package sfw_pkg;

  localparam int unsigned MaxRowsDefault = 1024;
  localparam int unsigned QueueDepth     = 4;

  localparam int unsigned IdxW    = 21;
  localparam int unsigned ColW    = 12;
  localparam int unsigned RowNumW = 10;
  localparam int unsigned WgtW    = 17;
  localparam int unsigned RatioW  = 16;
  localparam int unsigned ZoneW   = 2;
  localparam int unsigned DistW   = 13;
  localparam int unsigned ProdW   = 29;
  localparam int unsigned DenW    = 30;
  localparam int unsigned FracW   = 16;
  localparam int unsigned NumExtW = 46;

  localparam logic [ColW-1:0]   WidthReset = 12'd1920;
  localparam logic [RatioW-1:0] RatioReset = 16'd256;

  typedef enum logic {
    REG_IMAGE_WIDTH = 1'b0,
    REG_RAMP_RATIO  = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_PIXEL = 1'b1
  } kind_e;

  typedef enum logic [ZoneW-1:0] {
    ZONE_NONE  = 2'd0,
    ZONE_LEFT  = 2'd1,
    ZONE_RIGHT = 2'd2
  } zone_e;

  typedef struct packed {
    logic [ColW-1:0] left_lo;
    logic [ColW-1:0] left_hi;
    logic [ColW-1:0] right_lo;
    logic [ColW-1:0] right_hi;
  } bounds_t;

  typedef struct packed {
    kind_e              kind;
    logic [RowNumW-1:0] row_number;
    bounds_t            bounds;
    logic [IdxW-1:0]    pixel_index;
    logic [WgtW-1:0]    prior_weight;
  } item_t;

  typedef struct packed {
    logic            row_ok;
    logic [ColW-1:0] column;
    bounds_t         bounds;
    logic [WgtW-1:0] prior_weight;
  } pix_t;

  typedef struct packed {
    logic [ColW-1:0]   image_width;
    logic [RatioW-1:0] ramp_ratio;
  } cfg_t;

endpackage

>>> rtl/core/sfw_front.sv
module sfw_front import sfw_pkg::*; #(
  parameter int unsigned MaxRows = MaxRowsDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  out_valid_o,
  input  logic  out_full_i,
  output pix_t  out_item_o
);

  localparam int unsigned RowW  = $clog2(MaxRows);
  localparam int unsigned Steps = IdxW;

  logic [ColW-1:0] divisor;
  logic            en;

  logic                st_v_q    [0:Steps];
  logic [ColW-1:0]     st_rem_q  [0:Steps];
  logic [IdxW-1:0]     st_quo_q  [0:Steps];
  item_t               st_item_q [0:Steps];

  assign divisor    = (cfg_i.image_width == '0) ? ColW'(1) : cfg_i.image_width;
  assign en         = !out_full_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_v_q[0] <= 1'b0;
    end else if (en) begin
      st_v_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_item_q[0] <= in_item_i;
      st_rem_q[0]  <= '0;
      st_quo_q[0]  <= '0;
    end
  end

  // restoring division of the index by the width, one quotient bit per stage
  for (genvar s = 1; s <= Steps; s++) begin : g_div
    logic [ColW:0]   cand;
    logic            ge;
    logic [ColW:0]   diff;

    assign cand = {st_rem_q[s-1], st_item_q[s-1].pixel_index[Steps-s]};
    assign ge   = cand >= {1'b0, divisor};
    assign diff = cand - {1'b0, divisor};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_v_q[s] <= 1'b0;
      end else if (en) begin
        st_v_q[s] <= st_v_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        st_item_q[s] <= st_item_q[s-1];
        st_rem_q[s]  <= ge ? diff[ColW-1:0] : cand[ColW-1:0];
        st_quo_q[s]  <= {st_quo_q[s-1][IdxW-2:0], ge};
      end
    end
  end

  // row table: loads write and pixels read at the same stage, so order holds
  logic                        is_load;
  logic                        load_ok;
  logic                        row_ok;
  logic [IdxW-1:0]             addr_full;
  logic [RowW-1:0]             addr;
  logic [$bits(bounds_t)-1:0]  mem [MaxRows];
  logic [$bits(bounds_t)-1:0]  rd_q;
  logic                        m_v_q;
  logic                        m_row_ok_q;
  logic [ColW-1:0]             m_col_q;
  logic [WgtW-1:0]             m_prior_q;

  assign is_load   = st_item_q[Steps].kind == KIND_LOAD;
  assign load_ok   = IdxW'(st_item_q[Steps].row_number) < IdxW'(MaxRows);
  assign row_ok    = st_quo_q[Steps] < IdxW'(MaxRows);
  assign addr_full = is_load ? IdxW'(st_item_q[Steps].row_number) : st_quo_q[Steps];
  assign addr      = addr_full[RowW-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (st_v_q[Steps] && is_load && load_ok) begin
        mem[addr] <= st_item_q[Steps].bounds;
      end
      rd_q       <= mem[addr];
      m_row_ok_q <= row_ok;
      m_col_q    <= st_rem_q[Steps];
      m_prior_q  <= st_item_q[Steps].prior_weight;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (en) begin
      m_v_q <= st_v_q[Steps] && !is_load;
    end
  end

  assign out_valid_o             = m_v_q;
  assign out_item_o.row_ok       = m_row_ok_q;
  assign out_item_o.column       = m_col_q;
  assign out_item_o.bounds       = bounds_t'(rd_q);
  assign out_item_o.prior_weight = m_prior_q;

endmodule

>>> rtl/core/sfw_queue.sv
module sfw_queue import sfw_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  pix_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output pix_t data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  pix_t            slot_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign data_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

>>> rtl/core/sfw_back.sv
module sfw_back import sfw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              in_valid_i,
  output logic              in_pop_o,
  input  pix_t              in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [WgtW-1:0]   out_weight_o,
  output zone_e             out_zone_o
);

  localparam int unsigned Steps = WgtW;

  logic en;
  logic out_v_q;

  assign en       = !out_v_q || out_ready_i;
  assign in_pop_o = en && in_valid_i;

  // stage 0: span test and distances
  logic [DistW-1:0] x1;
  logic [DistW-1:0] x0;
  logic             in_l;
  logic             in_r;
  zone_e            zone;
  logic [DistW-1:0] lo_sel;
  logic [DistW-1:0] hi2_sel;

  assign x0   = {1'b0, in_item_i.column};
  assign x1   = x0 + DistW'(1);
  assign in_l = in_item_i.row_ok
             && (x1 >= {1'b0, in_item_i.bounds.left_lo})
             && (x0 <= {1'b0, in_item_i.bounds.left_hi} + DistW'(2));
  assign in_r = in_item_i.row_ok
             && (x1 >= {1'b0, in_item_i.bounds.right_lo})
             && (x0 <= {1'b0, in_item_i.bounds.right_hi} + DistW'(2));

  always_comb begin
    if (in_l) begin
      zone    = ZONE_LEFT;
      lo_sel  = {1'b0, in_item_i.bounds.left_lo};
      hi2_sel = {1'b0, in_item_i.bounds.left_hi} + DistW'(2);
    end else if (in_r) begin
      zone    = ZONE_RIGHT;
      lo_sel  = {1'b0, in_item_i.bounds.right_lo};
      hi2_sel = {1'b0, in_item_i.bounds.right_hi} + DistW'(2);
    end else begin
      zone    = ZONE_NONE;
      lo_sel  = '0;
      hi2_sel = '0;
    end
  end

  logic             b0_v_q;
  zone_e            b0_zone_q;
  logic [DistW-1:0] b0_dl_q;
  logic [DistW-1:0] b0_dr_q;
  logic [WgtW-1:0]  b0_prior_q;

  logic             b1_v_q;
  zone_e            b1_zone_q;
  logic [ProdW-1:0] b1_a_q;
  logic [ProdW-1:0] b1_b_q;
  logic [WgtW-1:0]  b1_prior_q;

  logic             b2_v_q;
  zone_e            b2_zone_q;
  logic [DenW-1:0]  b2_den_q;
  logic [ProdW-1:0] b2_num_q;
  logic [WgtW-1:0]  b2_prior_q;

  logic [NumExtW-1:0] n_ext;

  assign n_ext = {b2_num_q, {FracW{1'b0}}} + NumExtW'(b2_den_q >> 1);

  logic              d_v_q     [0:Steps];
  zone_e             d_zone_q  [0:Steps];
  logic              d_zero_q  [0:Steps];
  logic [DenW-1:0]   d_den_q   [0:Steps];
  logic [DenW-1:0]   d_rem_q   [0:Steps];
  logic [WgtW-1:0]   d_low_q   [0:Steps];
  logic [WgtW-1:0]   d_quo_q   [0:Steps];
  logic [WgtW-1:0]   d_prior_q [0:Steps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_v_q   <= 1'b0;
      b1_v_q   <= 1'b0;
      b2_v_q   <= 1'b0;
      d_v_q[0] <= 1'b0;
    end else if (en) begin
      b0_v_q   <= in_valid_i;
      b1_v_q   <= b0_v_q;
      b2_v_q   <= b1_v_q;
      d_v_q[0] <= b2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b0_zone_q   <= zone;
      b0_dl_q     <= x1 - lo_sel;
      b0_dr_q     <= hi2_sel - x0;
      b0_prior_q  <= in_item_i.prior_weight;

      b1_zone_q   <= b0_zone_q;
      b1_a_q      <= ProdW'(b0_dl_q * cfg_i.ramp_ratio);
      b1_b_q      <= ProdW'({b0_dr_q, 8'b0});
      b1_prior_q  <= b0_prior_q;

      b2_zone_q   <= b1_zone_q;
      b2_den_q    <= DenW'(b1_a_q) + DenW'(b1_b_q);
      b2_num_q    <= (b1_zone_q == ZONE_LEFT) ? b1_a_q : b1_b_q;
      b2_prior_q  <= b1_prior_q;

      d_zone_q[0]  <= b2_zone_q;
      d_zero_q[0]  <= b2_den_q == '0;
      d_den_q[0]   <= b2_den_q;
      d_rem_q[0]   <= DenW'(n_ext[NumExtW-1:WgtW]);
      d_low_q[0]   <= n_ext[WgtW-1:0];
      d_quo_q[0]   <= '0;
      d_prior_q[0] <= b2_prior_q;
    end
  end

  // rounded quotient, one bit per stage
  for (genvar s = 1; s <= Steps; s++) begin : g_div
    logic [DenW:0] cand;
    logic          ge;
    logic [DenW:0] diff;

    assign cand = {d_rem_q[s-1], d_low_q[s-1][Steps-s]};
    assign ge   = cand >= {1'b0, d_den_q[s-1]};
    assign diff = cand - {1'b0, d_den_q[s-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d_v_q[s] <= 1'b0;
      end else if (en) begin
        d_v_q[s] <= d_v_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        d_zone_q[s]  <= d_zone_q[s-1];
        d_zero_q[s]  <= d_zero_q[s-1];
        d_den_q[s]   <= d_den_q[s-1];
        d_rem_q[s]   <= ge ? diff[DenW-1:0] : cand[DenW-1:0];
        d_low_q[s]   <= d_low_q[s-1];
        d_quo_q[s]   <= {d_quo_q[s-1][WgtW-2:0], ge};
        d_prior_q[s] <= d_prior_q[s-1];
      end
    end
  end

  logic [WgtW-1:0] weight;
  logic [WgtW-1:0] out_w_q;
  zone_e           out_zone_q;

  always_comb begin
    if (d_zone_q[Steps] == ZONE_NONE) begin
      weight = d_prior_q[Steps];
    end else if (d_zero_q[Steps]) begin
      weight = '0;
    end else begin
      weight = d_quo_q[Steps];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= d_v_q[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_w_q    <= weight;
      out_zone_q <= d_zone_q[Steps];
    end
  end

  assign out_valid_o  = out_v_q;
  assign out_weight_o = out_w_q;
  assign out_zone_o   = out_zone_q;

endmodule

>>> rtl/core/seam_feather_weight.sv
// Feather blend weight engine. Load items (tuser 0) write one row's left and
// right overlap bounds into the row table; pixel items (tuser 1) return one
// Q1.16 weight and a zone code. Throughput is one item per cycle while the
// output is ready and the queue is not full. A pixel passes through the front
// divider that splits the index into row and column plus the row table read,
// the queue, and the back end (span test, ratio multiply, 17-stage rounded
// divide, output register). Loads produce no result. Registers: index 0 image
// width, index 1 Q8.8 ramp ratio; write them only while the block is idle.
module seam_feather_weight import sfw_pkg::*; #(
  parameter int unsigned MaxRows = MaxRowsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // row_number, left_lo, left_hi, right_lo, right_hi, pixel_index, prior_weight
  input  logic [95:0] s_axis_tdata,
  // kind
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // weight, zero fill
  output logic [23:0] m_axis_tdata,
  // zone
  output logic [1:0]  m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t            cfg_q;
  item_t           in_item;
  logic            f_valid;
  pix_t            f_item;
  logic            q_full;
  logic            q_valid;
  pix_t            q_item;
  logic            q_pop;
  logic [WgtW-1:0] weight;
  zone_e           zone;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width <= WidthReset;
      cfg_q.ramp_ratio  <= RatioReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH: cfg_q.image_width <= cfg_data_i[ColW-1:0];
        REG_RAMP_RATIO:  cfg_q.ramp_ratio  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_item.kind            = kind_e'(s_axis_tuser);
  assign in_item.row_number      = s_axis_tdata[9:0];
  assign in_item.bounds.left_lo  = s_axis_tdata[21:10];
  assign in_item.bounds.left_hi  = s_axis_tdata[33:22];
  assign in_item.bounds.right_lo = s_axis_tdata[45:34];
  assign in_item.bounds.right_hi = s_axis_tdata[57:46];
  assign in_item.pixel_index     = s_axis_tdata[78:58];
  assign in_item.prior_weight    = s_axis_tdata[95:79];

  sfw_front #(
    .MaxRows (MaxRows)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .out_valid_o (f_valid),
    .out_full_i  (q_full),
    .out_item_o  (f_item)
  );

  sfw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .data_i  (f_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_item)
  );

  sfw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (q_valid),
    .in_pop_o     (q_pop),
    .in_item_i    (q_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_weight_o (weight),
    .out_zone_o   (zone)
  );

  assign m_axis_tdata = {7'b0, weight};
  assign m_axis_tuser = zone;

endmodule

>>> rtl/core/sfw_checker.sv
`include "seam_feather_weight_defines.svh"

module sfw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  `SFW_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")
  `SFW_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
  `SFW_ASSERT_NEVER(a_zone_code, m_axis_tvalid && m_axis_tuser == 2'd3, "bad zone")
  `SFW_ASSERT_NEVER(a_ramp_range, m_axis_tvalid && m_axis_tuser != 2'd0 && m_axis_tdata > 24'd65536, "ramp weight above one")

endmodule

bind seam_feather_weight sfw_checker u_sfw_checker (.*);

>>> tb/seam_feather_weight_tb.sv
module seam_feather_weight_tb;
  import sfw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        kind;
    logic [9:0]  row;
    logic [11:0] llo, lhi, rlo, rhi;
    logic [20:0] idx;
    logic [16:0] prior;
  } stim_t;

  typedef struct {
    logic [16:0] weight;
    logic [1:0]  zone;
  } wgt_t;

  typedef struct {
    stim_t s;
    logic  known;
    wgt_t  w;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  seam_feather_weight DUT (.*);

  always #1 clk_i = ~clk_i;

  logic [11:0] width_q = 12'd1920;
  logic [15:0] ratio_q = 16'd256;
  logic [11:0] tab_llo [1024];
  logic [11:0] tab_lhi [1024];
  logic [11:0] tab_rlo [1024];
  logic [11:0] tab_rhi [1024];
  bit          row_loaded [1024];
  wgt_t        weights_due [$];
  int          errors = 0;
  bit          sent_all = 1'b0;

  function automatic logic [16:0] ramp(int x, logic [11:0] lo, logic [11:0] hi, bit rising);
    longint dl, dr, a, b, den, num;
    dl = x - (int'(lo) - 1);
    dr = (int'(hi) + 2) - x;
    a = dl * ratio_q;
    b = dr * 256;
    den = a + b;
    num = rising ? a : b;
    if (den == 0) return '0;
    return 17'((num * 65536 + den / 2) / den);
  endfunction

  function automatic wgt_t blend_weight(stim_t s);
    wgt_t w;
    int wd, rw, x;
    w.weight = s.prior;
    w.zone = ZONE_NONE;
    wd = (width_q == 0) ? 1 : width_q;
    rw = s.idx / wd;
    x = s.idx % wd;
    if (rw < 1024) begin
      if (x >= int'(tab_llo[rw]) - 1 && x <= int'(tab_lhi[rw]) + 2) begin
        w.weight = ramp(x, tab_llo[rw], tab_lhi[rw], 1);
        w.zone = ZONE_LEFT;
      end else if (x >= int'(tab_rlo[rw]) - 1 && x <= int'(tab_rhi[rw]) + 2) begin
        w.weight = ramp(x, tab_rlo[rw], tab_rhi[rw], 0);
        w.zone = ZONE_RIGHT;
      end
    end
    return w;
  endfunction

  task automatic idle_clocks(int n);
    repeat (n) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [15:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (r == REG_IMAGE_WIDTH) width_q = v[11:0];
    else ratio_q = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (weights_due.size() != 0) @(posedge clk_i);
    idle_clocks(60);
  endtask

  task automatic send(stim_t s, bit known, wgt_t w, int gap);
    wgt_t p;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      idle_clocks(gap);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= s.kind;
    s_axis_tdata <= {2'b0, s.prior, s.idx, s.rhi, s.rlo, s.lhi, s.llo, s.row};
    do @(posedge clk_i); while (!s_axis_tready);
    if (s.kind == KIND_LOAD) begin
      tab_llo[s.row] = s.llo; tab_lhi[s.row] = s.lhi;
      tab_rlo[s.row] = s.rlo; tab_rhi[s.row] = s.rhi;
      row_loaded[s.row] = 1'b1;
    end else begin
      p = blend_weight(s);
      weights_due.push_back(known ? w : p);
    end
    @(negedge clk_i);
  endtask

  function automatic stim_t mk_load(logic [9:0] r, int a, int b, int c, int d);
    stim_t s;
    s = '{KIND_LOAD, r, 12'(a), 12'(b), 12'(c), 12'(d), 21'($urandom), 17'($urandom)};
    return s;
  endfunction

  function automatic stim_t mk_pix(int idx, int prior);
    stim_t s;
    s = '{KIND_PIXEL, 10'($urandom), 12'($urandom), 12'($urandom),
          12'($urandom), 12'($urandom), 21'(idx), 17'(prior)};
    return s;
  endfunction

  function automatic int rnd_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
  endfunction

  always @(posedge clk_i) begin
    wgt_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (weights_due.size() == 0) begin
        $display("%t unexpected result weight %0d zone %0d", $time,
                 m_axis_tdata[16:0], m_axis_tuser);
        errors++;
      end else begin
        e = weights_due.pop_front();
        if (m_axis_tdata[16:0] !== e.weight || m_axis_tuser !== e.zone ||
            m_axis_tdata[23:17] !== '0) begin
          $display("%t expected weight %0d zone %0d, got weight %0d zone %0d", $time,
                   e.weight, e.zone, m_axis_tdata[16:0], m_axis_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    bit stall_phase;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      stall_phase = sent_all ? 0 : $urandom_range(0, 2) != 0;
      if (stall_phase) begin
        @(negedge clk_i);
        while (!(m_axis_tvalid && m_axis_tready)) @(negedge clk_i);
        m_axis_tready <= 1'b0;
        idle_clocks($urandom_range(0, 12));
      end
    end
  end

  initial begin
    row_t dir [$];
    stim_t s;
    int n, wsel, rsel;
    logic [9:0] r;
    int rows_w [5] = '{1, 2, 2048, 0, 640};
    int rats [5] = '{1, 65535, 256, 0, 777};

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // width 1920, ratio 256: row 0 left 10..20, right 100..110
    dir.push_back('{mk_load(0, 10, 20, 100, 110), 0, '{0, 0}});
    dir.push_back('{mk_load(1, 0, 4095, 0, 0), 0, '{0, 0}});
    dir.push_back('{mk_load(1023, 4095, 4095, 5, 3), 0, '{0, 0}});
    dir.push_back('{mk_load(2, 50, 40, 30, 20), 0, '{0, 0}});
    dir.push_back('{mk_pix(9, 0), 1, '{0, ZONE_LEFT}});
    dir.push_back('{mk_pix(22, 0), 1, '{65536, ZONE_LEFT}});
    dir.push_back('{mk_pix(15, 0), 0, '{0, 0}});
    dir.push_back('{mk_pix(99, 5), 1, '{65536, ZONE_RIGHT}});
    dir.push_back('{mk_pix(112, 5), 1, '{0, ZONE_RIGHT}});
    dir.push_back('{mk_pix(50, 65536), 1, '{65536, ZONE_NONE}});
    dir.push_back('{mk_pix(60, 131071), 1, '{131071, ZONE_NONE}});
    dir.push_back('{mk_pix(1920, 0), 0, '{0, 0}});
    dir.push_back('{mk_pix(3839, 0), 0, '{0, 0}});
    dir.push_back('{mk_pix(3840 + 45, 7), 0, '{0, 0}});
    dir.push_back('{mk_pix(1023 * 1920 + 4000 % 1920, 3), 0, '{0, 0}});
    dir.push_back('{mk_pix(2097151, 1234), 1, '{1234, ZONE_NONE}});
    dir.push_back('{mk_pix(1024 * 1920, 99), 1, '{99, ZONE_NONE}});
    foreach (dir[i]) send(dir[i].s, dir[i].known, dir[i].w, rnd_gap());

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      write_reg(REG_IMAGE_WIDTH, 16'(rows_w[ph]));
      write_reg(REG_RAMP_RATIO, 16'(rats[ph]));
      wsel = (width_q == 0) ? 1 : width_q;
      // ensure every reachable row is loaded before pixels touch it
      n = (2097151 / wsel + 1 < 1024) ? 2097151 / wsel + 1 : 1024;
      for (int k = 0; k < 1024; k++)
        if (!row_loaded[k] && k < n) begin
          s = mk_load(k, $urandom_range(0, 40), $urandom_range(0, 80),
                      $urandom_range(0, 2048), $urandom_range(0, 2048));
          send(s, 0, '{0, 0}, $urandom_range(0, 20) == 0 ? rnd_gap() : 0);
        end
      for (int k = 0; k < 100; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          r = 10'($urandom);
          if ($urandom_range(0, 1)) begin
            rsel = $urandom_range(0, wsel);
            s = mk_load(r, rsel, rsel + $urandom_range(0, 30),
                        $urandom_range(0, wsel + 2), 12'($urandom));
          end else s = mk_load(r, $urandom, $urandom, $urandom, $urandom);
          s.llo = 12'(s.llo); s.lhi = 12'(s.lhi);
          send(s, 0, '{0, 0}, rnd_gap());
        end else begin
          if ($urandom_range(0, 9) == 0) s = mk_pix($urandom, $urandom);
          else begin
            rsel = $urandom_range(0, (n < 1024) ? n - 1 : 1023);
            s = mk_pix(rsel * wsel + $urandom_range(0, wsel - 1),
                       $urandom_range(0, 65536));
            if (s.idx != rsel * wsel + s.idx % wsel) s.idx = 21'($urandom);
          end
          wsel = wsel;
          send(s, 0, '{0, 0}, rnd_gap());
        end
      end
    end
    sent_all = 1'b1;
    drain();
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end
endmodule
